// ----- src/matrix_multiply_4x4_defines.svh -----
// assertion macros used by the checker of the block
// clk and rst are taken from the scope where a macro is used
`ifndef MATRIX_MULTIPLY_4X4_DEFINES_SVH
`define MATRIX_MULTIPLY_4X4_DEFINES_SVH

// same-cycle implication
`define MM4_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MM4_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mm4_pkg.sv -----
package mm4_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int CELLS     = DIM * DIM;
  localparam int IDX_W     = $clog2(CELLS);
  localparam int K_W       = $clog2(DIM);
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W + $clog2(DIM);

  typedef enum logic [1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_START  = 2'd2
  } kind_t;

  // control that travels alongside the read data into the mac unit
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

// ----- src/mm4_in_if.sv -----
interface mm4_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  row;
  logic [1:0]  col;
  logic signed [31:0] value;

  modport source (output valid, output kind, output row, output col, output value,
                  input ready);
  modport sink (input valid, input kind, input row, input col, input value,
                output ready);
endinterface

// ----- src/mm4_out_if.sv -----
interface mm4_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_row;
  logic [1:0]  out_col;
  logic signed [31:0] product;
  logic        last;

  modport source (output valid, output out_row, output out_col, output product,
                  output last, input ready);
  modport sink (input valid, input out_row, input out_col, input product,
                input last, output ready);
endinterface

// ----- src/mm4_ram.sv -----
module mm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/mm4_mac.sv -----
module mm4_mac (
  input  logic                     clk,
  input  logic                     rst,
  input  mm4_pkg::mac_ctl_t        ctl,
  input  logic [mm4_pkg::DATA_W-1:0] a,
  input  logic [mm4_pkg::DATA_W-1:0] b,
  output logic                     done,
  output logic [mm4_pkg::DATA_W-1:0] result
);

  logic signed [mm4_pkg::PROD_W-1:0] prod;
  logic                              prod_v;
  logic                              prod_first;
  logic                              prod_last;
  logic signed [mm4_pkg::ACC_W-1:0]  acc;
  logic signed [mm4_pkg::ACC_W-1:0]  prod_ext;
  logic signed [mm4_pkg::ACC_W-1:0]  shifted;
  logic [mm4_pkg::ACC_W-mm4_pkg::DATA_W:0] upper;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v    <= 1'b0;
      prod_last <= 1'b0;
      done      <= 1'b0;
    end else begin
      prod_v    <= ctl.valid;
      prod_last <= ctl.last;
      done      <= prod_v && prod_last;
    end
    prod       <= $signed(a) * $signed(b);
    prod_first <= ctl.first;
    if (prod_v) begin
      acc <= prod_first ? prod_ext : acc + prod_ext;
    end
  end

  assign prod_ext = {{(mm4_pkg::ACC_W - mm4_pkg::PROD_W){prod[mm4_pkg::PROD_W-1]}}, prod};

  // floor of the exact sum, then clamp to the signed word range
  assign shifted = acc >>> mm4_pkg::FRAC_BITS;
  assign upper   = shifted[mm4_pkg::ACC_W-1:mm4_pkg::DATA_W-1];

  always_comb begin
    if ((&upper) || !(|upper)) begin
      result = shifted[mm4_pkg::DATA_W-1:0];
    end else if (shifted[mm4_pkg::ACC_W-1]) begin
      result = {1'b1, {(mm4_pkg::DATA_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(mm4_pkg::DATA_W-1){1'b1}}};
    end
  end

endmodule

// ----- src/matrix_multiply_4x4.sv -----
// 4x4 matrix product in signed Q16.16 fixed point.
// cmd carries load and start items. kind load A / load B writes value into
// the element at row, col of that operand (out-of-range or unused kinds are
// dropped); kind start runs the product, and its other fields are ignored.
// res carries the 16 product elements in row-major order with out_row,
// out_col and last set on the final element. Each sum is kept at full width,
// floored by 16 fraction bits and saturated to 32 bits.
// Loads are written as they arrive while idle and cmd stays ready for them.
// A start drops cmd ready until the last element sits in the output register.
// Each element takes 4 reads through the single read port of each operand
// RAM into one shared multiplier; the read data, the product and the sum
// are registered in turn, and the sequencer waits for the sum before it
// hands it to the output register and moves on. A stalled receiver
// holds the current element in the output register and the sequencer waits.
// Operands are undefined after reset until loaded; reset clears the sequencer
// and the output valid, and res is empty.
module matrix_multiply_4x4 (
  input logic       clk,
  input logic       rst,
  mm4_in_if.sink    cmd,
  mm4_out_if.source res
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_PUSH = 4'b1000
  } state_t;

  state_t                     state;
  logic [mm4_pkg::K_W-1:0]    i;
  logic [mm4_pkg::K_W-1:0]    j;
  logic [mm4_pkg::K_W-1:0]    k;
  mm4_pkg::mac_ctl_t          ctl;
  logic                       cmd_xfer;
  logic                       in_range;
  logic                       we_a;
  logic                       we_b;
  logic [mm4_pkg::IDX_W-1:0]  waddr;
  logic [mm4_pkg::IDX_W-1:0]  raddr_a;
  logic [mm4_pkg::IDX_W-1:0]  raddr_b;
  logic [mm4_pkg::DATA_W-1:0] rdata_a;
  logic [mm4_pkg::DATA_W-1:0] rdata_b;
  logic                       mac_done;
  logic [mm4_pkg::DATA_W-1:0] mac_result;
  logic                       issue;
  logic                       k_last;
  logic                       j_last;
  logic                       i_last;
  logic                       out_free;
  logic                       push;
  logic                       res_valid;
  logic [1:0]                 res_row;
  logic [1:0]                 res_col;
  logic [mm4_pkg::DATA_W-1:0] res_product;
  logic                       res_last;

  assign cmd.ready = (state == ST_IDLE);
  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign in_range  = (32'(cmd.row) < mm4_pkg::DIM) && (32'(cmd.col) < mm4_pkg::DIM);
  assign we_a      = cmd_xfer && in_range && (cmd.kind == mm4_pkg::KIND_LOAD_A);
  assign we_b      = cmd_xfer && in_range && (cmd.kind == mm4_pkg::KIND_LOAD_B);
  assign waddr     = mm4_pkg::IDX_W'(32'(cmd.row) * mm4_pkg::DIM + 32'(cmd.col));

  assign issue   = (state == ST_RUN);
  assign k_last  = (k == mm4_pkg::K_W'(mm4_pkg::DIM - 1));
  assign j_last  = (j == mm4_pkg::K_W'(mm4_pkg::DIM - 1));
  assign i_last  = (i == mm4_pkg::K_W'(mm4_pkg::DIM - 1));
  assign raddr_a = mm4_pkg::IDX_W'(32'(i) * mm4_pkg::DIM + 32'(k));
  assign raddr_b = mm4_pkg::IDX_W'(32'(k) * mm4_pkg::DIM + 32'(j));

  assign out_free = !res_valid || res.ready;
  assign push     = (state == ST_PUSH) && out_free;

  mm4_ram #(.WIDTH(mm4_pkg::DATA_W), .DEPTH(mm4_pkg::CELLS)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (cmd.value),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mm4_ram #(.WIDTH(mm4_pkg::DATA_W), .DEPTH(mm4_pkg::CELLS)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (cmd.value),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  mm4_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .a      (rdata_a),
    .b      (rdata_b),
    .done   (mac_done),
    .result (mac_result)
  );

  // ctl lines up with the registered ram read data
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.valid <= issue;
      ctl.first <= issue && (k == '0);
      ctl.last  <= issue && k_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_xfer && (cmd.kind == mm4_pkg::KIND_START)) begin
            i     <= '0;
            j     <= '0;
            k     <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (k_last) begin
            k     <= '0;
            state <= ST_WAIT;
          end else begin
            k <= k + 1'b1;
          end
        end
        ST_WAIT: begin
          if (mac_done) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            if (j_last) begin
              j <= '0;
              i <= i + 1'b1;
            end else begin
              j <= j + 1'b1;
            end
            state <= (i_last && j_last) ? ST_IDLE : ST_RUN;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (push) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
    if (push) begin
      res_row     <= 2'(i);
      res_col     <= 2'(j);
      res_product <= mac_result;
      res_last    <= i_last && j_last;
    end
  end

  assign res.valid   = res_valid;
  assign res.out_row = res_row;
  assign res.out_col = res_col;
  assign res.product = res_product;
  assign res.last    = res_last;

endmodule

// ----- src/mm4_chk.sv -----
`include "matrix_multiply_4x4_defines.svh"

module mm4_chk (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic [1:0]  cmd_kind,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  res_row,
  input logic [1:0]  res_col,
  input logic [31:0] res_product,
  input logic        res_last
);

  // a stalled result holds
  `MM4_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_product) && $stable(res_last), "stalled result changed")

  // a start transfer makes the block busy
  `MM4_ASSERT_NXT(a_start_busy, cmd_valid && cmd_ready && (cmd_kind == mm4_pkg::KIND_START), !cmd_ready, "block still ready after start")

  // while an element other than the last waits, the product is still running
  `MM4_ASSERT(a_busy_mid, res_valid && !res_last, !cmd_ready, "ready before product finished")

  // the final element sits at the far corner
  `MM4_ASSERT(a_last_pos, res_valid && res_last, (res_row == 2'(mm4_pkg::DIM - 1)) && (res_col == 2'(mm4_pkg::DIM - 1)), "last flag on wrong element")

endmodule

bind matrix_multiply_4x4 mm4_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .cmd_kind    (cmd.kind),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_row     (res.out_row),
  .res_col     (res.out_col),
  .res_product (res.product),
  .res_last    (res.last)
);
